// ===== rtl/core/ffba_pkg.sv =====
// shared types, constants and the microcode rom of the first-fit byte heap allocator
// no dependencies; used by ffba_heap, ffba_seq and first_fit_byte_heap_allocator
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

	localparam int MEM_BYTES    = 32;
	localparam int HEADER_BYTES = 5;
	localparam int SIZE_W       = 5;
	localparam int ADDR_W       = 5;
	localparam int OFF_W        = 5;
	localparam int HA_W         = $clog2(MEM_BYTES);
	// stored bytes only ever hold 0, 1 or a size value
	localparam int DATA_W       = SIZE_W;
	// widest walk position: jump from the last byte past a block of maximum size, plus a window
	localparam int POS_W        = $clog2(MEM_BYTES + 2 * HEADER_BYTES + 2 * (2 ** SIZE_W));
	localparam int STEP_W       = 4;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0] block_offset;
		logic             fail;
	} rsp_t;

	localparam logic MODE_FREE = 1'b1;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE    = 4'd0;
	localparam step_t ST_A_LOOP  = 4'd1;
	localparam step_t ST_A_SCAN  = 4'd2;
	localparam step_t ST_A_HIT   = 4'd3;
	localparam step_t ST_A_TAKE  = 4'd4;
	localparam step_t ST_A_TAKE2 = 4'd5;
	localparam step_t ST_A_FAIL  = 4'd6;
	localparam step_t ST_F_CHK   = 4'd7;
	localparam step_t ST_F_LEN   = 4'd8;
	localparam step_t ST_F_ZERO  = 4'd9;
	localparam step_t ST_F_DONE  = 4'd10;
	localparam step_t ST_F_FAIL  = 4'd11;

	typedef enum logic [2:0] {
		C_NEVER,
		C_NOREQ,
		C_REQ_FREE,
		C_NOFIT,
		C_Q_END,
		C_MARK,
		C_BADHDR,
		C_ZERO_END
	} cond_t;

	typedef enum logic [1:0] { P_HOLD, P_CLEAR, P_HIT } pop_t;
	typedef enum logic [1:0] { Q_HOLD, Q_FROM_P, Q_HDR, Q_INC } qop_t;
	typedef enum logic [1:0] { L_HOLD, L_WIN, L_FREE } lop_t;
	typedef enum logic [1:0] { R_Q, R_Q1, R_HDR } rsel_t;
	typedef enum logic [1:0] { W_NONE, W_MARK_P, W_SIZE_P1, W_ZERO_Q } wop_t;
	typedef enum logic [1:0] { O_NONE, O_ALLOC, O_FREE, O_FAIL } oop_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
	} jmp_t;

	typedef struct packed {
		logic  accept;
		jmp_t  ja;
		jmp_t  jb;
		step_t next;
		pop_t  pop;
		qop_t  qop;
		lop_t  lop;
		rsel_t rsel;
		wop_t  wop;
		oop_t  oop;
	} ctl_t;

	typedef struct packed {
		logic no_req;
		logic req_free;
		logic nofit;
		logic q_end;
		logic mark;
		logic badhdr;
		logic zero_end;
	} cond_flags_t;

	function automatic ctl_t uw(input logic acc, input cond_t ca, input step_t ta,
			input cond_t cb, input step_t tb, input step_t nx, input pop_t po,
			input qop_t qo, input lop_t lo, input rsel_t rs, input wop_t wo,
			input oop_t oo);
		ctl_t w;
		w = '{acc, '{ca, ta}, '{cb, tb}, nx, po, qo, lo, rs, wo, oo};
		return w;
	endfunction

	// microprogram: ja has priority over jb, otherwise fall through to next
	function automatic ctl_t ucode_rom(input step_t s);
		ctl_t w;
		case (s)
			ST_IDLE: begin
				w = uw(1'b1, C_NOREQ, ST_IDLE, C_REQ_FREE, ST_F_CHK, ST_A_LOOP,
					P_CLEAR, Q_HOLD, L_HOLD, R_Q, W_NONE, O_NONE);
			end
			ST_A_LOOP: begin
				w = uw(1'b0, C_NOFIT, ST_A_FAIL, C_NEVER, ST_IDLE, ST_A_SCAN,
					P_HOLD, Q_FROM_P, L_WIN, R_Q, W_NONE, O_NONE);
			end
			ST_A_SCAN: begin
				w = uw(1'b0, C_Q_END, ST_A_TAKE, C_MARK, ST_A_HIT, ST_A_SCAN,
					P_HOLD, Q_INC, L_HOLD, R_Q, W_NONE, O_NONE);
			end
			ST_A_HIT: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_A_LOOP,
					P_HIT, Q_HOLD, L_HOLD, R_Q, W_NONE, O_NONE);
			end
			ST_A_TAKE: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_A_TAKE2,
					P_HOLD, Q_HOLD, L_HOLD, R_Q, W_MARK_P, O_NONE);
			end
			ST_A_TAKE2: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_IDLE,
					P_HOLD, Q_HOLD, L_HOLD, R_Q, W_SIZE_P1, O_ALLOC);
			end
			ST_A_FAIL: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_IDLE,
					P_HOLD, Q_HOLD, L_HOLD, R_Q, W_NONE, O_FAIL);
			end
			ST_F_CHK: begin
				w = uw(1'b0, C_BADHDR, ST_F_FAIL, C_NEVER, ST_IDLE, ST_F_LEN,
					P_HOLD, Q_HDR, L_HOLD, R_HDR, W_NONE, O_NONE);
			end
			ST_F_LEN: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_F_ZERO,
					P_HOLD, Q_HOLD, L_FREE, R_Q1, W_NONE, O_NONE);
			end
			ST_F_ZERO: begin
				w = uw(1'b0, C_ZERO_END, ST_F_DONE, C_NEVER, ST_IDLE, ST_F_ZERO,
					P_HOLD, Q_INC, L_HOLD, R_Q, W_ZERO_Q, O_NONE);
			end
			ST_F_DONE: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_IDLE,
					P_HOLD, Q_HOLD, L_HOLD, R_Q, W_NONE, O_FREE);
			end
			ST_F_FAIL: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_IDLE,
					P_HOLD, Q_HOLD, L_HOLD, R_Q, W_NONE, O_FAIL);
			end
			default: begin
				w = uw(1'b0, C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, ST_IDLE,
					P_HOLD, Q_HOLD, L_HOLD, R_Q, W_NONE, O_NONE);
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ffba_heap.sv =====
// heap byte store: flip-flop array cleared by reset, one read and one write port
// depends on ffba_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffba_heap (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [ffba_pkg::HA_W-1:0]   rd_idx,
	output logic      [ffba_pkg::DATA_W-1:0] rd_data,
	input  wire logic                       we,
	input  wire logic [ffba_pkg::HA_W-1:0]   wr_idx,
	input  wire logic [ffba_pkg::DATA_W-1:0] wr_data
);
	import ffba_pkg::*;

	logic [DATA_W-1:0] mem_q [MEM_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEM_BYTES; i++) begin
				mem_q[i] <= '0;
			end
		end else if (we) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/core/ffba_seq.sv =====
// microcode sequencer: step counter, control rom and two-way conditional jump
// depends on ffba_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffba_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ffba_pkg::cond_flags_t flags,
	input  wire logic                  stall,
	output ffba_pkg::ctl_t             ctl,
	output logic                       fall
);
	import ffba_pkg::*;

	step_t pc_q;
	step_t pc_next;
	logic  take_a;
	logic  take_b;

	function automatic logic cond_sel(input cond_t c, input cond_flags_t f);
		logic r;
		case (c)
			C_NEVER:    r = 1'b0;
			C_NOREQ:    r = f.no_req;
			C_REQ_FREE: r = f.req_free;
			C_NOFIT:    r = f.nofit;
			C_Q_END:    r = f.q_end;
			C_MARK:     r = f.mark;
			C_BADHDR:   r = f.badhdr;
			C_ZERO_END: r = f.zero_end;
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

	assign ctl    = ucode_rom(pc_q);
	assign take_a = cond_sel(ctl.ja.cond, flags);
	assign take_b = cond_sel(ctl.jb.cond, flags);
	assign fall   = !take_a && !take_b;

	always_comb begin
		if (take_a) begin
			pc_next = ctl.ja.target;
		end else if (take_b) begin
			pc_next = ctl.jb.target;
		end else begin
			pc_next = ctl.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!stall) begin
			pc_q <= pc_next;
		end
	end

	property p_step_valid;
		@(posedge clk) disable iff (!arst_n) pc_q <= ST_F_FAIL;
	endproperty
	a_step_valid: assert property (p_step_valid) else $error("step counter left the program");

	property p_idle_return;
		@(posedge clk) disable iff (!arst_n)
			(!stall && ctl.oop != O_NONE) |=> pc_q == ST_IDLE;
	endproperty
	a_idle_return: assert property (p_idle_return) else $error("no return to idle after result");

	property p_stall_hold;
		@(posedge clk) disable iff (!arst_n) stall |=> $stable(pc_q);
	endproperty
	a_stall_hold: assert property (p_stall_hold) else $error("step moved during stall");

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_byte_heap_allocator.sv =====
// top level of the first-fit byte heap allocator: datapath around the microcode sequencer
// depends on ffba_pkg, ffba_heap and ffba_seq
`timescale 1ns / 1ps
`default_nettype none

// First-fit allocator over a 32-byte heap that reset clears. Each request takes one result.
// Allocate walks the heap from offset 0 one byte per cycle, jumping past every used mark it
// meets (reading that block's size from the byte after the mark), and writes the mark and
// size into a five-byte header when the header plus data window is free; it returns the
// data offset, or fail when no window fits. Free checks the mark in front of the address
// and zeroes the header and data one byte per cycle. The single heap read port sets the
// pace. A new request is taken only once the previous result has been placed in the
// output register, which holds it until taken.
module first_fit_byte_heap_allocator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ffba_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output ffba_pkg::rsp_t      rsp
);
	import ffba_pkg::*;

	ctl_t              ctl;
	logic              fall;
	logic              stall;
	cond_flags_t       flags;

	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [POS_W-1:0]  p_q;
	logic [POS_W-1:0]  q_q;
	logic [POS_W-1:0]  lim_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic [POS_W-1:0]  q_inc;
	logic [POS_W-1:0]  addr_w;
	logic [POS_W-1:0]  hdr_pos;
	logic [POS_W-1:0]  win_end;
	logic [POS_W-1:0]  hit_size;
	logic [POS_W-1:0]  alloc_off;
	logic [HA_W-1:0]   rd_idx;
	logic [DATA_W-1:0] rd_data;
	logic              heap_we;
	logic [HA_W-1:0]   wr_idx;
	logic [DATA_W-1:0] wr_data;
	logic              accept;

	localparam logic [DATA_W-1:0] USED_MARK = DATA_W'(1);

	ffba_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.stall  (stall),
		.ctl    (ctl),
		.fall   (fall)
	);

	ffba_heap u_heap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.we      (heap_we),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	assign req_ready = ctl.accept;
	assign accept    = req_valid && req_ready;
	// a result step waits while the output register is still occupied
	assign stall     = (ctl.oop != O_NONE) && out_valid_q && !rsp_ready;

	assign q_inc     = q_q + POS_W'(1);
	assign addr_w    = POS_W'(addr_q);
	assign hdr_pos   = addr_w - POS_W'(HEADER_BYTES);
	assign win_end   = p_q + POS_W'(HEADER_BYTES) + POS_W'(size_q);
	// size byte of a mark in the last heap byte reads as zero
	assign hit_size  = (q_q >= POS_W'(MEM_BYTES)) ? '0 : POS_W'(rd_data);
	assign alloc_off = p_q + POS_W'(HEADER_BYTES);

	always_comb begin
		case (ctl.rsel)
			R_Q:     rd_idx = q_q[HA_W-1:0];
			R_Q1:    rd_idx = q_inc[HA_W-1:0];
			R_HDR:   rd_idx = hdr_pos[HA_W-1:0];
			default: rd_idx = q_q[HA_W-1:0];
		endcase
	end

	always_comb begin
		flags.no_req   = !req_valid;
		flags.req_free = req.mode == MODE_FREE;
		flags.nofit    = win_end > POS_W'(MEM_BYTES);
		flags.q_end    = q_q >= lim_q;
		flags.mark     = rd_data == USED_MARK;
		flags.badhdr   = (addr_w < POS_W'(HEADER_BYTES)) || (addr_w >= POS_W'(MEM_BYTES))
			|| (rd_data != USED_MARK);
		flags.zero_end = (q_q >= lim_q) || (q_q >= POS_W'(MEM_BYTES));
	end

	// heap writes only on fall-through steps
	always_comb begin
		heap_we = !stall && fall && (ctl.wop != W_NONE);
		case (ctl.wop)
			W_MARK_P: begin
				wr_idx  = p_q[HA_W-1:0];
				wr_data = USED_MARK;
			end
			W_SIZE_P1: begin
				wr_idx  = HA_W'(p_q + POS_W'(1));
				wr_data = DATA_W'(size_q);
			end
			W_ZERO_Q: begin
				wr_idx  = q_q[HA_W-1:0];
				wr_data = '0;
			end
			default: begin
				wr_idx  = q_q[HA_W-1:0];
				wr_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q <= req.size;
			addr_q <= req.address;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			case (ctl.pop)
				P_CLEAR: p_q <= '0;
				// q already points one past the mark here
				P_HIT:   p_q <= q_q + POS_W'(HEADER_BYTES - 1) + hit_size;
				default: p_q <= p_q;
			endcase
			case (ctl.qop)
				Q_FROM_P: q_q <= p_q;
				Q_HDR:    q_q <= hdr_pos;
				Q_INC:    q_q <= q_inc;
				default:  q_q <= q_q;
			endcase
			case (ctl.lop)
				L_WIN:   lim_q <= win_end;
				L_FREE:  lim_q <= addr_w + POS_W'(rd_data);
				default: lim_q <= lim_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.oop != O_NONE && !stall) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			case (ctl.oop)
				O_ALLOC: out_q <= '{block_offset: alloc_off[OFF_W-1:0], fail: 1'b0};
				O_FREE:  out_q <= '{block_offset: '0, fail: 1'b0};
				O_FAIL:  out_q <= '{block_offset: '0, fail: 1'b1};
				default: out_q <= out_q;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n) accept |=> !req_ready;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept)
		else $error("request taken while previous one in flight");

	property p_no_write_on_accept;
		@(posedge clk) disable iff (!arst_n) accept |-> !heap_we;
	endproperty
	a_no_write_on_accept: assert property (p_no_write_on_accept)
		else $error("heap written in idle step");

	property p_alloc_fits;
		@(posedge clk) disable iff (!arst_n)
			(ctl.oop == O_ALLOC && !stall) |-> win_end <= POS_W'(MEM_BYTES);
	endproperty
	a_alloc_fits: assert property (p_alloc_fits) else $error("allocated window past heap end");

	property p_result_held;
		@(posedge clk) disable iff (!arst_n)
			stall |=> out_valid_q && $stable(out_q);
	endproperty
	a_result_held: assert property (p_result_held) else $error("pending result overwritten");

endmodule

`default_nettype wire
